/* rtl/hcs_pkg.sv */
// Shared types and constants for the Hamiltonian cycle search block.
// Used by every module under rtl/ but hcs_checker; depends on nothing.

package hcs_pkg;

    localparam int ROW_SLOTS = 16;   // adjacency rows held, one per vertex code
    localparam int VTX_W     = 4;    // vertex code width
    localparam int CNT_W     = 5;    // counts that must hold ROW_SLOTS itself
    localparam int ROW_W     = 16;   // adjacency row width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_SCAN,
        ST_POPW,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] addr;
        logic [ROW_W-1:0] data;
    } t_adj_wr;

    typedef struct packed {
        logic             en;
        logic [VTX_W-1:0] addr;
    } t_adj_rd;

    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] waddr;
        logic [VTX_W-1:0] wdata;
        logic             re;
        logic [VTX_W-1:0] raddr;
    } t_stk_op;

endpackage

/* rtl/hcs_adj_ram.sv */
// Adjacency row storage: one write port, one registered read port.
// Depends on hcs_pkg.

module hcs_adj_ram (
    input  logic                        i_clk,
    input  hcs_pkg::t_adj_wr            i_wr,
    input  hcs_pkg::t_adj_rd            i_rd,
    output logic [hcs_pkg::ROW_W-1:0]   o_rdata
);
    import hcs_pkg::*;

    logic [ROW_W-1:0] r_mem [ROW_SLOTS];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // hold the last row read until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/hcs_stack_ram.sv */
// Path stack storage: one write port, one registered read port.
// Depends on hcs_pkg.

module hcs_stack_ram (
    input  logic                        i_clk,
    input  hcs_pkg::t_stk_op            i_op,
    output logic [hcs_pkg::VTX_W-1:0]   o_rdata
);
    import hcs_pkg::*;

    logic [VTX_W-1:0] r_mem [ROW_SLOTS];
    logic [VTX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_op.we) begin
            r_mem[i_op.waddr] <= i_op.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.re) begin
            r_rdata <= r_mem[i_op.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/hcs_seq.sv */
// Backtracking sequencer: while scanning, tests one candidate vertex per cycle
// against the fetched adjacency row; pushes and pops the path stack, then
// streams the cycle. Depends on hcs_pkg; drives hcs_adj_ram and hcs_stack_ram.

module hcs_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hcs_pkg::CNT_W-1:0]   i_n,
    output logic                        o_idle,
    output hcs_pkg::t_adj_rd            o_adj_rd,
    input  logic [hcs_pkg::ROW_W-1:0]   i_adj_row,
    output hcs_pkg::t_stk_op            o_stk,
    input  logic [hcs_pkg::VTX_W-1:0]   i_stk_rdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_out_found,
    output logic [hcs_pkg::VTX_W-1:0]   o_out_vertex,
    output logic                        o_out_last
);
    import hcs_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_depth;
    logic [CNT_W-1:0]   r_cand;
    logic [ROW_W-1:0]   r_visited;
    logic [VTX_W-1:0]   r_tail;
    logic [VTX_W-1:0]   r_k;
    logic               r_out_valid;
    logic               r_out_found;
    logic [VTX_W-1:0]   r_out_vertex;
    logic               r_out_last;

    logic w_full, w_hit, w_exhaust, w_back, w_ok, w_top;
    logic w_out_free, w_emit_last, w_load_hit, w_load_fail;

    assign w_full      = (r_depth == r_n);
    assign w_exhaust   = (r_cand >= r_n);
    assign w_hit       = !w_exhaust && !r_visited[r_cand[VTX_W-1:0]]
                         && i_adj_row[r_cand[VTX_W-1:0]];
    assign w_ok        = w_full && i_adj_row[0];
    assign w_back      = w_full ? !i_adj_row[0] : (!w_hit && w_exhaust);
    assign w_top       = (r_depth <= CNT_W'(1));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_emit_last = (({1'b0, r_k} + CNT_W'(1)) == r_n);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_START;
            ST_START:   n_state = ST_FETCH;
            ST_FETCH:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_ok) begin
                    n_state = ST_EMIT_RD;
                end else if (w_back) begin
                    n_state = w_top ? ST_FAIL : ST_POPW;
                end else if (!w_full && w_hit) begin
                    n_state = ST_FETCH;
                end
            end
            ST_POPW:    n_state = ST_FETCH;
            ST_EMIT_RD: n_state = ST_EMIT_WR;
            ST_EMIT_WR: if (w_out_free) n_state = w_emit_last ? ST_IDLE : ST_EMIT_RD;
            ST_FAIL:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_adj_rd    = '{en: (r_state == ST_FETCH), addr: r_tail};
        o_stk       = '0;
        w_load_hit  = 1'b0;
        w_load_fail = 1'b0;
        unique case (r_state)
            ST_START: begin
                o_stk.we = 1'b1;
            end
            ST_SCAN: begin
                if (!w_full && w_hit) begin
                    o_stk.we    = 1'b1;
                    o_stk.waddr = r_depth[VTX_W-1:0];
                    o_stk.wdata = r_cand[VTX_W-1:0];
                end else if (w_back && !w_top) begin
                    // fetch the vertex below the one being dropped
                    o_stk.re    = 1'b1;
                    o_stk.raddr = VTX_W'(r_depth - CNT_W'(2));
                end
            end
            ST_EMIT_RD: begin
                o_stk.re    = 1'b1;
                o_stk.raddr = r_k;
            end
            ST_EMIT_WR: w_load_hit  = w_out_free;
            ST_FAIL:    w_load_fail = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_hit || w_load_fail) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (i_start) r_n <= i_n;
            ST_START: begin
                r_depth   <= CNT_W'(1);
                r_visited <= ROW_W'(1);
                r_tail    <= '0;
                r_cand    <= CNT_W'(1);
            end
            ST_SCAN: begin
                if (w_ok) begin
                    r_k <= '0;
                end else if (w_back) begin
                    // drop the tail, resume just past it
                    r_depth   <= r_depth - CNT_W'(1);
                    r_visited <= r_visited & ~(ROW_W'(1) << r_tail);
                    r_cand    <= {1'b0, r_tail} + CNT_W'(1);
                end else if (!w_full && w_hit) begin
                    r_depth   <= r_depth + CNT_W'(1);
                    r_visited <= r_visited | (ROW_W'(1) << r_cand[VTX_W-1:0]);
                    r_tail    <= r_cand[VTX_W-1:0];
                    r_cand    <= CNT_W'(1);
                end else begin
                    r_cand <= r_cand + CNT_W'(1);
                end
            end
            ST_POPW: r_tail <= i_stk_rdata;
            ST_EMIT_WR: if (w_out_free) r_k <= r_k + VTX_W'(1);
            default: ;
        endcase
        if (w_load_hit) begin
            r_out_found  <= 1'b1;
            r_out_vertex <= i_stk_rdata;
            r_out_last   <= w_emit_last;
        end else if (w_load_fail) begin
            r_out_found  <= 1'b0;
            r_out_vertex <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_found  = r_out_found;
    assign o_out_vertex = r_out_vertex;
    assign o_out_last   = r_out_last;

endmodule

/* rtl/hamiltonian_cycle_search.sv */
// Hamiltonian cycle search, top level.
// Input stream carries adjacency rows, one word per row; the word with
// s_axis_tlast high stores its row and starts a depth-first backtracking
// search from vertex 0 over the vertex_count vertices in use.
// Rows are taken one per cycle while the block is idle. Once the search
// starts, s_axis_tready stays low until the last result word is loaded into
// the output register.
// Search time is data dependent: each scan step tries a candidate, checks the
// closing edge or finds the row exhausted; a push adds a row fetch, a pop adds
// a stack read and a row fetch, and a start writes vertex 0 and fetches its row.
// Each result word takes a stack read, then an output load, when not stalled.
// Output stream: one word per vertex of the cycle, tuser = found, tlast on
// the final word; no cycle gives a single word with found low and tlast high.
// A stalled receiver holds the word in the output register and the sequencer
// waits; rows for the next graph can still be loaded once the search is done.
// Configuration: one write channel for vertex_count, always ready; write it
// only while the block is idle. Synchronous active-low reset returns to idle
// with vertex_count = 16 and an empty output; adjacency rows are not cleared.
// Depends on hcs_pkg, hcs_adj_ram, hcs_stack_ram, hcs_seq.

module hamiltonian_cycle_search #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // row_index[3:0], row_bits[19:4]
    input  logic                        s_axis_tlast,   // last_row
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // vertex[3:0]
    output logic                        m_axis_tuser,   // found
    output logic                        m_axis_tlast,   // last
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hcs_pkg::CNT_W-1:0]   i_cfg_data      // vertex_count
);
    import hcs_pkg::*;

    localparam int VLIMIT_I = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
    localparam logic [CNT_W-1:0] VLIMIT = CNT_W'(VLIMIT_I);

    logic [CNT_W-1:0] r_vcount;
    logic [CNT_W-1:0] w_n;
    logic             w_idle, w_accept, w_start;
    t_adj_wr          w_adj_wr;
    t_adj_rd          w_adj_rd;
    t_stk_op          w_stk;
    logic [ROW_W-1:0] w_adj_row;
    logic [VTX_W-1:0] w_stk_rdata;
    logic [VTX_W-1:0] w_vertex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_W'(ROW_SLOTS);
        end else if (i_cfg_valid) begin
            r_vcount <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_vcount == '0) begin
            w_n = CNT_W'(1);
        end else if (r_vcount > VLIMIT) begin
            w_n = VLIMIT;
        end else begin
            w_n = r_vcount;
        end
    end

    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;
    assign w_start       = w_accept && s_axis_tlast;
    assign w_adj_wr      = '{we: w_accept, addr: s_axis_tdata[3:0], data: s_axis_tdata[19:4]};

    hcs_adj_ram u_adj (
        .i_clk   (i_clk),
        .i_wr    (w_adj_wr),
        .i_rd    (w_adj_rd),
        .o_rdata (w_adj_row)
    );

    hcs_stack_ram u_stk (
        .i_clk   (i_clk),
        .i_op    (w_stk),
        .o_rdata (w_stk_rdata)
    );

    hcs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_n          (w_n),
        .o_idle       (w_idle),
        .o_adj_rd     (w_adj_rd),
        .i_adj_row    (w_adj_row),
        .o_stk        (w_stk),
        .i_stk_rdata  (w_stk_rdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_found  (m_axis_tuser),
        .o_out_vertex (w_vertex),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, w_vertex};

endmodule

/* rtl/hcs_checker.sv */
// Port-level checks for hamiltonian_cycle_search, attached by bind.
// Depends on the top level's ports only.

module hcs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast
);

    // stalled result word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // a not-found word is the whole run
    a_fail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("not-found word is not a single last word");

    // the final row starts the search and holds off input
    a_search_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after the final row");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

endmodule

bind hamiltonian_cycle_search hcs_checker u_hcs_checker (.*);

/* tb/hamiltonian_cycle_search_test.sv */
`timescale 1ns / 100ps

// Self-checking testbench for hamiltonian_cycle_search: loads adjacency rows, runs searches
// on hand-built and random graphs, and checks every output word against its own backtracking
// search or a hand-set expected word. Depends on hcs_pkg and the RTL top level.

module hamiltonian_cycle_search_test;
    import hcs_pkg::*;

    localparam int ITEM_TARGET    = 450;
    localparam int COST_CAP       = 3000;   // search steps a random graph may take
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NO_CFG         = -1;

    typedef logic [ROW_SLOTS-1:0][ROW_W-1:0] t_adj_image;
    typedef logic [ROW_SLOTS-1:0][VTX_W-1:0] t_vertex_path;

    typedef struct packed {
        logic             found;
        logic [VTX_W-1:0] vertex;
        logic             last;
    } t_cycle_word;

    typedef struct packed {
        int               cfg;
        logic [VTX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        logic             last_row;
        bit               typed;
        logic             typed_found;
    } t_row_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;     // row_index[3:0], row_bits[19:4]
    logic                 s_axis_tlast = 1'b0;   // last_row
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;          // vertex[3:0]
    logic                 m_axis_tuser;          // found
    logic                 m_axis_tlast;          // last
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;       // vertex_count

    // mirror of the block's state
    t_adj_image           adj_mirror = '0;
    logic [ROW_SLOTS-1:0] rows_written = '0;
    logic [CNT_W-1:0]     count_reg = 5'd16;
    t_cycle_word          cycle_q[$];

    int                   fail_count = 0;
    int                   items_sent = 0;
    int                   burst_left = 0;
    int                   words_seen = 0;
    int                   quiet_cycles = 0;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    logic [7:0]           stall_phase = '0;
    t_cycle_word          want_word;

    hamiltonian_cycle_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [ROW_W-1:0] rand_row();
        logic [31:0] draw;
        draw = $urandom;
        return draw[ROW_W-1:0];
    endfunction

    function automatic int unsigned used_vertices(input logic [CNT_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > ROW_SLOTS) return ROW_SLOTS;
        return raw;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned sel;
        int unsigned v;
        sel = $urandom_range(0, 19);
        if (sel == 0) v = 0;
        else if (sel == 1) v = $urandom_range(17, 31);
        else if (sel <= 4) v = $urandom_range(10, 16);
        else v = $urandom_range(1, 9);
        return v[CNT_W-1:0];
    endfunction

    // Depth-first search from vertex 0, lowest unvisited neighbor first. Returns the
    // number of steps taken; gives up once that passes COST_CAP.
    function automatic int unsigned walk_cycle(input t_adj_image img, input int unsigned n,
                                               output t_vertex_path path, output bit closed);
        int unsigned          depth;
        int unsigned          start;
        int unsigned          v;
        int unsigned          cost;
        logic [VTX_W-1:0]     tail;
        logic [VTX_W-1:0]     back;
        logic [ROW_SLOTS-1:0] visited;
        bit                   advanced;
        bit                   done;
        depth   = 1;
        start   = 1;
        cost    = 0;
        path    = '0;
        visited = 16'h0001;
        closed  = 1'b0;
        done    = 1'b0;
        while (!done) begin
            advanced = 1'b0;
            if (depth == n) begin
                cost++;
                if (img[path[n-1]][0]) begin
                    closed = 1'b1;
                    done   = 1'b1;
                end
            end else begin
                tail = path[depth-1];
                v    = start;
                while (!advanced && v < n) begin
                    cost++;
                    if (!visited[v] && img[tail][v]) begin
                        path[depth] = v[VTX_W-1:0];
                        visited[v]  = 1'b1;
                        depth++;
                        start    = 1;
                        advanced = 1'b1;
                        cost += 2;
                    end
                    v++;
                end
            end
            if (!done && !advanced) begin
                if (depth <= 1) begin
                    done = 1'b1;
                end else begin
                    depth--;
                    back          = path[depth];
                    visited[back] = 1'b0;
                    path[depth]   = '0;
                    start         = back + 1;
                    cost += 3;
                end
            end
            if (cost > COST_CAP) done = 1'b1;
        end
        return cost;
    endfunction

    function automatic t_row_item row_entry(input int cfg, input logic [VTX_W-1:0] idx,
                                            input logic [ROW_W-1:0] bits, input logic last_row,
                                            input bit typed, input logic typed_found);
        t_row_item e;
        e.cfg         = cfg;
        e.idx         = idx;
        e.bits        = bits;
        e.last_row    = last_row;
        e.typed       = typed;
        e.typed_found = typed_found;
        return e;
    endfunction

    // Store the row; on the last row, queue the words the search must produce.
    task automatic absorb_row(input t_row_item r);
        t_vertex_path path;
        bit           closed;
        int unsigned  n;
        int unsigned  cost;
        t_cycle_word  w;
        adj_mirror[r.idx]   = r.bits;
        rows_written[r.idx] = 1'b1;
        if (r.last_row) begin
            if (r.typed) begin
                w.found  = r.typed_found;
                w.vertex = '0;
                w.last   = 1'b1;
                cycle_q.push_back(w);
            end else begin
                n    = used_vertices(count_reg);
                cost = walk_cycle(adj_mirror, n, path, closed);
                if (!closed) begin
                    w.found  = 1'b0;
                    w.vertex = '0;
                    w.last   = 1'b1;
                    cycle_q.push_back(w);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        w.found  = 1'b1;
                        w.vertex = path[k];
                        w.last   = (k == n - 1);
                        cycle_q.push_back(w);
                    end
                end
            end
        end
    endtask

    task automatic send_word(input t_row_item r);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, r.bits, r.idx};
        s_axis_tlast  <= r.last_row;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_row(r);
        items_sent++;
    endtask

    // Drop the input, wait for all pending words, then give the block time to go idle.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (cycle_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        count_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_graph_run();
        t_adj_image           img;
        t_vertex_path         order;
        t_vertex_path         scratch;
        logic [ROW_SLOTS-1:0] dirty;
        logic [ROW_W-1:0]     in_mask;
        logic [VTX_W-1:0]     tmp;
        t_row_item            rows[$];
        t_row_item            r;
        t_row_item            swap;
        int unsigned          n;
        int unsigned          kind;
        int unsigned          k;
        int unsigned          j;
        int unsigned          cost;
        bit                   closed;

        if ($urandom_range(0, 3) == 0) write_count(pick_count());
        n       = used_vertices(count_reg);
        in_mask = (n == ROW_SLOTS) ? '1 : ((16'h0001 << n) - 16'h0001);
        img     = adj_mirror;
        // rows never loaded since reset must be loaded before any search reads them
        dirty   = ~rows_written & in_mask;

        for (k = 0; k < ROW_SLOTS; k++) order[k] = k[VTX_W-1:0];
        for (k = n - 1; k > 1; k--) begin
            j        = $urandom_range(1, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end

        kind = $urandom_range(0, 4);
        if (kind == 4) begin
            repeat ($urandom_range(1, 3)) begin
                j        = $urandom_range(0, ROW_SLOTS - 1);
                img[j]   = rand_row();
                dirty[j] = 1'b1;
            end
        end else begin
            for (k = 0; k < n; k++) begin
                case (kind)
                    0:       img[k] = rand_row();
                    1:       img[k] = rand_row() & rand_row();
                    default: img[k] = rand_row() & rand_row() & rand_row();
                endcase
            end
            if (kind == 3)
                for (k = 0; k < n; k++) img[order[k]][order[(k + 1) % n]] = 1'b1;
            dirty = dirty | in_mask;
        end

        // fall back to a bare planted cycle when the search would run too long
        cost = walk_cycle(img, n, scratch, closed);
        if (cost > COST_CAP) begin
            for (k = 0; k < n; k++)
                img[order[k]] = (rand_row() & ~in_mask) | (16'h0001 << order[(k + 1) % n]);
            dirty = dirty | in_mask;
        end

        // rows past the vertex count are stored but must not change the result
        if (n < ROW_SLOTS && $urandom_range(0, 2) == 0) begin
            j        = $urandom_range(n, ROW_SLOTS - 1);
            img[j]   = rand_row();
            dirty[j] = 1'b1;
        end

        for (k = 0; k < ROW_SLOTS; k++) begin
            if (dirty[k]) begin
                r = row_entry(NO_CFG, k[VTX_W-1:0], img[k], 1'b0, 1'b0, 1'b0);
                rows.push_back(r);
            end
        end
        for (k = rows.size() - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            swap    = rows[k];
            rows[k] = rows[j];
            rows[j] = swap;
        end
        // most runs end in a search; the rest leave rows loaded without one
        if ($urandom_range(0, 9) != 0) begin
            r          = rows.pop_back();
            r.last_row = 1'b1;
            rows.push_back(r);
        end
        foreach (rows[i]) send_word(rows[i]);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(40, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= (stall_phase[1:0] == 2'b00);
            default: m_axis_tready <= (stall_phase[4:3] != 2'b11);
        endcase
        stall_phase <= stall_phase + 8'd1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cycle_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("word %0d: nothing expected, got found=%0b tdata=%0h last=%0b",
                             words_seen, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want_word = cycle_q.pop_front();
                if (m_axis_tuser !== want_word.found ||
                    m_axis_tdata !== {4'b0000, want_word.vertex} ||
                    m_axis_tlast !== want_word.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("word %0d: expected found=%0b vertex=%0d last=%0b, %s%0b %s%0h %s%0b",
                                 words_seen, want_word.found, want_word.vertex, want_word.last,
                                 "got found=", m_axis_tuser, "tdata=", m_axis_tdata,
                                 "last=", m_axis_tlast);
                end
            end
            words_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row_item directed_rows[$];
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // count 0 acts as one vertex: no self edge, then a self edge
        directed_rows.push_back(row_entry(0, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(row_entry(NO_CFG, 4'd0, 16'h0001, 1'b1, 1'b1, 1'b1));
        // two vertices, row 1 carries bits past the count
        directed_rows.push_back(row_entry(2, 4'd1, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(row_entry(NO_CFG, 4'd0, 16'h0002, 1'b1, 1'b0, 1'b0));
        // count above 16 clamps; ring 0 -> 1 -> ... -> 15 -> 0
        for (int k = 2; k < ROW_SLOTS - 1; k++)
            directed_rows.push_back(row_entry((k == 2) ? 31 : NO_CFG, k[VTX_W-1:0],
                                              16'h0001 << (k + 1), 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(row_entry(NO_CFG, 4'd15, 16'h0001, 1'b1, 1'b0, 1'b0));
        // vertex 0 with no edges
        directed_rows.push_back(row_entry(17, 4'd0, 16'h0000, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(row_entry(16, 4'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0));
        // one vertex, only an edge beyond the count
        directed_rows.push_back(row_entry(1, 4'd0, 16'h8000, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(row_entry(3, 4'd2, 16'h0003, 1'b1, 1'b0, 1'b0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg != NO_CFG)
                write_count(directed_rows[i].cfg[CNT_W-1:0]);
            send_word(directed_rows[i]);
        end

        while (items_sent < ITEM_TARGET) random_graph_run();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && cycle_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
